### sv/s256h_pkg.sv
// ============================================================================
// s256h_pkg
// Shared types, constants and the round-constant table of the SHA-256
// stream hasher.
// ============================================================================
`default_nettype none

package s256h_pkg;

   // Field widths
   localparam int WordBits   = 32;
   localparam int ByteBits   = 8;
   localparam int WindowBits = 512;

   // Byte positions inside a 64-byte block
   localparam logic [6:0] BLOCK_BYTES = 7'd64;
   localparam logic [6:0] LEN_OFFSET  = 7'd56;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [63:0] BLOCK_BITS = 64'd512;

   // Item kinds
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Eight 32-bit words, index 0 is H0 / working variable a
   typedef logic [0:7][WordBits-1:0] hash_words_type;

   localparam hash_words_type INIT_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // Input beat
   typedef struct packed {
      logic                kind;
      logic [ByteBits-1:0] msg_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [WordBits-1:0] digest_word;
      logic [2:0]          word_number;
      logic                last_word;
   } rsp_type;

   // Round constants K[0..63]
   function automatic logic [WordBits-1:0] round_k(input logic [5:0] idx);
      logic [WordBits-1:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### sv/s256h_round.sv
// ============================================================================
// s256h_round
// One SHA-256 compression round plus one message-schedule step. Shared by
// all 64 rounds of every block under the top-level sequencer.
// ============================================================================
`default_nettype none

module s256h_round (
   input  s256h_pkg::hash_words_type vars_cur,
   input  logic [31:0]               round_const,
   input  logic [511:0]              sched_window,
   output s256h_pkg::hash_words_type vars_next,
   output logic [31:0]               sched_word
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
   logic [31:0] w0, w1, w9, w14, sml_s0, sml_s1;

   // window word j sits at bits [511-32j -: 32]; word 0 is W[t]
   assign w0  = sched_window[511:480];
   assign w1  = sched_window[479:448];
   assign w9  = sched_window[223:192];
   assign w14 = sched_window[63:32];

   // schedule: W[t+16]
   always_comb begin
      sml_s0     = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      sml_s1     = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      sched_word = sml_s1 + w9 + sml_s0 + w0;
   end

   // round function
   always_comb begin
      a = vars_cur[0]; b = vars_cur[1]; c = vars_cur[2]; d = vars_cur[3];
      e = vars_cur[4]; f = vars_cur[5]; g = vars_cur[6]; h = vars_cur[7];
      big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      ch     = (e & f) ^ (~e & g);
      t1     = h + big_s1 + ch + round_const + w0;
      big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      maj    = (a & b) ^ (a & c) ^ (b & c);
      t2     = big_s0 + maj;
      vars_next[0] = t1 + t2;
      vars_next[1] = a;
      vars_next[2] = b;
      vars_next[3] = c;
      vars_next[4] = d + t1;
      vars_next[5] = e;
      vars_next[6] = f;
      vars_next[7] = g;
   end

endmodule

`default_nettype wire

### sv/sha256_stream_hasher_unit.sv
// ============================================================================
// sha256_stream_hasher_unit
// SHA-256 over a byte stream: bytes shift into a 512-bit block window, each
// full block runs 64 rounds on one shared round unit, finish pads and emits
// the digest as eight word beats.
// ============================================================================
//
//   channel  dir  handshake            beat
//   req      in   req_valid/req_stall  kind, msg_byte
//   rsp      out  rsp_valid/rsp_stall  digest_word, word_number, last_word
//
// Append beat: the byte that fills a block starts 64 rounds on the round unit
//   at one round per cycle, followed by a fold; other bytes only shift in.
// Finish beat: pads the rest of the block, then rounds and fold per block (one or
//   two blocks, a second block being all padding and length), then 8 result beats.
// Reset: synchronous; restores the initial hash and clears the fill and bit counters.
// req_stall is high whenever the sequencer is busy; rsp_stall only holds
//   the current digest word.
//
`default_nettype none

module sha256_stream_hasher_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  s256h_pkg::req_type  req_beat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output s256h_pkg::rsp_type  rsp_beat
);

   s256h_pkg::state_type       state_ff, state_in;
   logic [5:0]                 fill_ff, fill_in;
   logic [63:0]                bitcnt_ff, bitcnt_in;
   logic                       fin_ff, fin_in;
   s256h_pkg::hash_words_type  chain_ff, chain_in;
   s256h_pkg::hash_words_type  vars_ff, vars_in;
   logic [511:0]               win_ff, win_in;
   logic [63:0]                len_ff, len_in;
   logic [6:0]                 pos_ff, pos_in;
   logic                       lenblk_ff, lenblk_in;
   logic [5:0]                 rnd_ff, rnd_in;
   logic [2:0]                 widx_ff, widx_in;

   logic                       req_fire, rsp_fire;
   s256h_pkg::hash_words_type  vars_next;
   logic [31:0]                sched_word;

   // shared round unit
   s256h_round u_round (
      .vars_cur     (vars_ff),
      .round_const  (s256h_pkg::round_k(rnd_ff)),
      .sched_window (win_ff),
      .vars_next    (vars_next),
      .sched_word   (sched_word)
   );

   // handshake outputs
   always_comb begin
      req_stall             = (state_ff != s256h_pkg::ST_IDLE);
      rsp_valid             = (state_ff == s256h_pkg::ST_EMIT);
      rsp_beat.digest_word  = chain_ff[widx_ff];
      rsp_beat.word_number  = widx_ff;
      rsp_beat.last_word    = (widx_ff == 3'd7);
   end

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         s256h_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_beat.kind == s256h_pkg::KIND_FINISH) begin
                  state_in = s256h_pkg::ST_PAD;
               end else if (fill_ff == 6'd63) begin
                  state_in = s256h_pkg::ST_COMP;
               end
            end
         end
         s256h_pkg::ST_PAD: begin
            if (pos_ff == s256h_pkg::BLOCK_BYTES) state_in = s256h_pkg::ST_COMP;
         end
         s256h_pkg::ST_COMP: begin
            if (rnd_ff == 6'd63) state_in = s256h_pkg::ST_FOLD;
         end
         s256h_pkg::ST_FOLD: begin
            if (!fin_ff)        state_in = s256h_pkg::ST_IDLE;
            else if (lenblk_ff) state_in = s256h_pkg::ST_EMIT;
            else                state_in = s256h_pkg::ST_PAD;
         end
         s256h_pkg::ST_EMIT: begin
            if (rsp_fire && widx_ff == 3'd7) state_in = s256h_pkg::ST_IDLE;
         end
         default: state_in = s256h_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      fill_in   = fill_ff;
      bitcnt_in = bitcnt_ff;
      fin_in    = fin_ff;
      chain_in  = chain_ff;
      vars_in   = vars_ff;
      win_in    = win_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      lenblk_in = lenblk_ff;
      rnd_in    = rnd_ff;
      widx_in   = widx_ff;
      unique case (state_ff)
         s256h_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_beat.kind == s256h_pkg::KIND_APPEND) begin
                  win_in  = {win_ff[503:0], req_beat.msg_byte};
                  fill_in = fill_ff + 6'd1;
               end else begin
                  // pad marker; length block fits when 0x80 lands at or before byte 55
                  win_in    = {win_ff[503:0], s256h_pkg::PAD_BYTE};
                  len_in    = bitcnt_ff + {55'd0, fill_ff, 3'd0};
                  pos_in    = {1'b0, fill_ff} + 7'd1;
                  lenblk_in = (fill_ff < 6'd56);
                  fin_in    = 1'b1;
               end
            end
         end
         s256h_pkg::ST_PAD: begin
            if (pos_ff != s256h_pkg::BLOCK_BYTES) begin
               pos_in = pos_ff + 7'd1;
               if (lenblk_ff && pos_ff >= s256h_pkg::LEN_OFFSET) begin
                  win_in = {win_ff[503:0], len_ff[63:56]};
                  len_in = {len_ff[55:0], 8'd0};
               end else begin
                  win_in = {win_ff[503:0], 8'd0};
               end
            end
         end
         s256h_pkg::ST_COMP: begin
            vars_in = vars_next;
            win_in  = {win_ff[479:0], sched_word};
            rnd_in  = rnd_ff + 6'd1;
         end
         s256h_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + vars_ff[i];
            if (!fin_ff) bitcnt_in = bitcnt_ff + s256h_pkg::BLOCK_BITS;
            if (fin_ff && !lenblk_ff) begin
               // filler block done, length block starts empty
               lenblk_in = 1'b1;
               pos_in    = 7'd0;
            end
            widx_in = 3'd0;
         end
         s256h_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  chain_in  = s256h_pkg::INIT_HASH;
                  fill_in   = 6'd0;
                  bitcnt_in = 64'd0;
                  fin_in    = 1'b0;
               end
            end
         end
         default: ;
      endcase
      // load working variables on entry to the round loop
      if (state_in == s256h_pkg::ST_COMP && state_ff != s256h_pkg::ST_COMP) begin
         vars_in = chain_ff;
         rnd_in  = 6'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= s256h_pkg::ST_IDLE;
         fill_ff   <= 6'd0;
         bitcnt_ff <= 64'd0;
         fin_ff    <= 1'b0;
         chain_ff  <= s256h_pkg::INIT_HASH;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bitcnt_ff <= bitcnt_in;
         fin_ff    <= fin_in;
         chain_ff  <= chain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vars_ff   <= vars_in;
      win_ff    <= win_in;
      len_ff    <= len_in;
      pos_ff    <= pos_in;
      lenblk_ff <= lenblk_in;
      rnd_ff    <= rnd_in;
      widx_ff   <= widx_in;
   end

   // checks
   a_comp_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s256h_pkg::ST_COMP && rnd_ff == 6'd63) |=>
         (state_ff == s256h_pkg::ST_FOLD))
      else $error("round loop did not end after 64 rounds");

   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_beat.last_word) |=>
         (state_ff == s256h_pkg::ST_IDLE && fill_ff == 6'd0 && bitcnt_ff == 64'd0))
      else $error("state not cleared after last digest beat");

   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s256h_pkg::ST_PAD) |-> (pos_ff <= s256h_pkg::BLOCK_BYTES))
      else $error("pad position beyond block");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == s256h_pkg::ST_FOLD && widx_ff == 3'd0))
      else $error("digest output started outside fold");

endmodule

`default_nettype wire
